>>> hdl/dhtg_pkg.sv
// Shared types, sizes and constant tables for the decaying harmonic tone generator.
// Depends on nothing; imported by dhtg_ctrl, dhtg_dp and the top level.
package dhtg_pkg;

    // Sizes
    localparam int HARMONICS   = 5;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int SINE_VW     = 15;
    localparam int IDX_W       = 21;
    localparam int PHASE_W     = 24;
    localparam int VOL_W       = 16;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 24;
    localparam int SAMPLE_W    = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Harmonic counter and pipeline widths
    localparam int HN_W   = (HARMONICS > 2) ? $clog2(HARMONICS) : 1;
    localparam int CNT_W  = $clog2(HARMONICS + 2);
    localparam int TERM_W = SINE_VW + 16;            // |sin| * 2^16 / n
    localparam int ACC_W  = 35;                      // signed harmonic sum
    localparam int MAG_W  = ACC_W - 1;
    localparam int P1_W   = MAG_W + VOL_W;
    localparam int P2_W   = P1_W + 15;
    localparam int OUT_SH = 47;
    localparam int Q_W    = P2_W - OUT_SH;
    localparam logic [14:0] FULL_SCALE = 15'd32760;

    // Reciprocals ceil(2^35 / n) for n = 1..16, exact floor division of 31-bit values
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W     = 36;
    localparam int MUL_W       = SINE_VW + RECIP_W;
    localparam int TERM_SH     = RECIP_SHIFT - 16;
    localparam logic [RECIP_W-1:0] RECIP [16] = '{
        36'd34359738368, 36'd17179869184, 36'd11453246123, 36'd8589934592,
        36'd6871947674,  36'd5726623062,  36'd4908534053,  36'd4294967296,
        36'd3817748708,  36'd3435973837,  36'd3123612579,  36'd2863311531,
        36'd2643056798,  36'd2454267027,  36'd2290649225,  36'd2147483648
    };

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_START_VOLUME = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DECAY_FACTOR = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SAMPLE_COUNT = 2'd3;

    localparam logic [PHASE_W-1:0] RST_PHASE_STEP   = 24'd41848;
    localparam logic [VOL_W-1:0]   RST_START_VOLUME = 16'd13107;
    localparam logic [VOL_W-1:0]   RST_DECAY_FACTOR = 16'd65531;
    localparam logic [IDX_W-1:0]   RST_SAMPLE_COUNT = 21'd11025;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // beat accepted: apply restart, clear accumulator
        logic lk_en;     // sine lookup for the next harmonic
        logic mul_en;    // scale lookup by 1/n
        logic acc_en;    // add weighted term into the sum
        logic scale1;    // |sum| * volume
        logic scale2;    // * full scale, advance phase/volume/index
        logic out_load;  // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_dp_sts;

    // Quarter-wave sine table, entry k = round(32767 * sin((k + 0.5) * pi / (2 * depth)))
    typedef logic [SINE_VW-1:0] t_sine_rom [SINE_DEPTH];

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            a    = (64'(2 * k + 1) * PI_Q30) / (4 * SINE_DEPTH);
            a2   = (a * a) >> 30;
            term = a;
            s    = a;
            // Taylor series, six terms after x
            for (int j = 1; j <= 6; j++) begin
                term = (term * a2) >> 30;
                case (j)
                    1: term = term / 6;
                    2: term = term / 20;
                    3: term = term / 42;
                    4: term = term / 72;
                    5: term = term / 110;
                    default: term = term / 156;
                endcase
                if ((j & 1) != 0) begin
                    s = s - term;
                end else begin
                    s = s + term;
                end
            end
            v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = v[SINE_VW-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

>>> hdl/decaying_harmonic_tone_generator_top.sv
// Top level of the decaying harmonic tone generator: controller plus datapath.
// Depends on dhtg_pkg, dhtg_ctrl and dhtg_dp.
//
// Usage:
//   Each beat on the slave stream is one tick; tdata bit 0 is restart, which
//   returns phase, volume and sample index to their start values before the
//   sample is formed. Every tick yields one beat on the master stream: tdata
//   holds the signed 16-bit saturated sample, tlast marks the final sample of
//   the configured tone length.
//   Configuration: write enable, register index, data; index 0 phase step,
//   1 start volume, 2 decay factor, 3 sample count. Write only while idle.
// Timing:
//   One shared lookup/weight unit handles one harmonic per cycle behind a
//   three-stage pipeline, followed by scaling by volume and by full scale
//   and an output load. A new tick is accepted only after the previous
//   sample has been loaded into the output register.
//   The next tick is accepted while a finished sample still waits in the
//   output register; if the receiver stalls longer, the following sample
//   waits in the datapath and the slave side stays not ready.
// Reset: synchronous, active low; registers take their default values, the
//   tone state clears, the output stream goes empty.
module decaying_harmonic_tone_generator_top
    import dhtg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [0] restart, [7:1] zero
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [15:0] sample (signed)
    output logic                   o_m_axis_tlast,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [CFG_DW-1:0]      i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dhtg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    dhtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_restart   (i_s_axis_tdata[0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_sample  (o_m_axis_tdata),
        .o_m_last    (o_m_axis_tlast)
    );

endmodule

>>> hdl/dhtg_ctrl.sv
// Sequencer for the tone generator: input handshake and datapath command timing.
// Depends on dhtg_pkg (command/status structs, HARMONICS).
module dhtg_ctrl
    import dhtg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HARM   = 5'b00010,
        S_SCALE1 = 5'b00100,
        S_SCALE2 = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_HARM;
                    n_cnt   = '0;
                end
            end
            S_HARM: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HARMONICS + 1)) begin
                    n_state = S_SCALE1;
                end
            end
            S_SCALE1: n_state = S_SCALE2;
            S_SCALE2: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Commands: harmonic pipeline is lookup -> multiply -> accumulate
    assign o_s_ready     = (r_state == S_IDLE);
    assign o_cmd.start   = o_s_ready && i_s_valid;
    assign o_cmd.lk_en   = (r_state == S_HARM) && (r_cnt < CNT_W'(HARMONICS));
    assign o_cmd.mul_en  = (r_state == S_HARM) && (r_cnt >= CNT_W'(1))
                           && (r_cnt <= CNT_W'(HARMONICS));
    assign o_cmd.acc_en  = (r_state == S_HARM) && (r_cnt >= CNT_W'(2));
    assign o_cmd.scale1  = (r_state == S_SCALE1);
    assign o_cmd.scale2  = (r_state == S_SCALE2);
    assign o_cmd.out_load = (r_state == S_OUT) && i_sts.out_free;

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output loaded while occupied");
    a_start_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> o_cmd.lk_en && !o_s_ready)
        else $error("accepted beat did not start harmonic lookup");
    a_scale_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scale1 |=> o_cmd.scale2)
        else $error("scale steps out of order");
    a_acc_before_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scale1 |-> $past(o_cmd.acc_en) && !$past(o_cmd.lk_en))
        else $error("scaling before harmonic sum complete");
`endif

endmodule

>>> hdl/dhtg_dp.sv
// Datapath: configuration registers, tone state, harmonic sum unit, scaling and output register.
// Depends on dhtg_pkg (sizes, sine table, reciprocals, command/status structs).
module dhtg_dp
    import dhtg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                i_restart,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic [SAMPLE_W-1:0] o_m_sample,
    output logic                o_m_last
);

    // Configuration registers
    logic [PHASE_W-1:0] r_phase_step;
    logic [VOL_W-1:0]   r_start_vol;
    logic [VOL_W-1:0]   r_decay;
    logic [IDX_W-1:0]   r_sample_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= RST_PHASE_STEP;
            r_start_vol    <= RST_START_VOLUME;
            r_decay        <= RST_DECAY_FACTOR;
            r_sample_count <= RST_SAMPLE_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata[PHASE_W-1:0];
                CFG_START_VOLUME: r_start_vol    <= i_cfg_wdata[VOL_W-1:0];
                CFG_DECAY_FACTOR: r_decay        <= i_cfg_wdata[VOL_W-1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Tone state
    logic [PHASE_W-1:0] r_phase;
    logic [VOL_W-1:0]   r_volume;
    logic [IDX_W-1:0]   r_index;
    logic [2*VOL_W-1:0] vol_prod;
    logic [IDX_W-1:0]   final_idx;
    logic               is_last;

    assign vol_prod  = (2*VOL_W)'(r_volume) * (2*VOL_W)'(r_decay);
    assign final_idx = r_sample_count - IDX_W'(1);
    assign is_last   = (r_index == final_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_volume <= RST_START_VOLUME;
            r_index  <= '0;
        end else if (i_cmd.start && i_restart) begin
            r_phase  <= '0;
            r_volume <= r_start_vol;
            r_index  <= '0;
        end else if (i_cmd.scale2) begin
            r_phase  <= r_phase + r_phase_step;
            r_volume <= vol_prod[2*VOL_W-1:VOL_W];
            r_index  <= is_last ? '0 : r_index + IDX_W'(1);
        end
    end

    // Harmonic lookup stage: phase n*p from repeated add, quadrant mirror of table
    logic [PHASE_W-1:0] r_hphase;
    logic [HN_W-1:0]    r_hnum;
    logic [1:0]         quad;
    logic [SINE_AW-1:0] pos;
    logic [SINE_VW-1:0] r_lk_mag;
    logic               r_lk_neg;
    logic [HN_W-1:0]    r_lk_n;

    assign quad = r_hphase[PHASE_W-1 -: 2];
    assign pos  = quad[0] ? ~r_hphase[PHASE_W-3 -: SINE_AW] : r_hphase[PHASE_W-3 -: SINE_AW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hphase <= i_restart ? '0 : r_phase;
            r_hnum   <= '0;
        end else if (i_cmd.lk_en) begin
            r_hphase <= r_hphase + r_phase;
            r_hnum   <= r_hnum + HN_W'(1);
            r_lk_mag <= SINE_ROM[pos];
            r_lk_neg <= quad[1];
            r_lk_n   <= r_hnum;
        end
    end

    // Weight stage: floor(|sin| * 2^16 / n) by reciprocal multiply
    logic [MUL_W-1:0]  wprod;
    logic [TERM_W-1:0] r_term;
    logic              r_term_neg;

    assign wprod = MUL_W'(r_lk_mag) * MUL_W'(RECIP[4'(r_lk_n)]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_term     <= wprod[TERM_SH +: TERM_W];
            r_term_neg <= r_lk_neg;
        end
    end

    // Accumulate signed terms (truncation toward zero kept by sign-magnitude weighting)
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] term_s;

    assign term_s = ACC_W'(r_term);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_term_neg ? r_acc - term_s : r_acc + term_s;
        end
    end

    // Scaling: |sum| * volume, then * full scale
    logic [ACC_W-1:0] acc_abs;
    logic [P1_W-1:0]  r_p1;
    logic             r_neg1;
    logic [P2_W-1:0]  r_p2;
    logic             r_neg2;
    logic             r_last;

    assign acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale1) begin
            r_p1   <= P1_W'(acc_abs[MAG_W-1:0]) * P1_W'(r_volume);
            r_neg1 <= r_acc[ACC_W-1];
        end
        if (i_cmd.scale2) begin
            r_p2   <= P2_W'(r_p1) * P2_W'(FULL_SCALE);
            r_neg2 <= r_neg1;
            r_last <= is_last;
        end
    end

    // Shift, restore sign, saturate
    logic [Q_W-1:0]      q;
    logic [SAMPLE_W-1:0] sat_sample;

    assign q = r_p2[OUT_SH +: Q_W];

    always_comb begin
        if (r_neg2) begin
            if (q > Q_W'(32768)) begin
                sat_sample = 16'h8000;
            end else begin
                sat_sample = SAMPLE_W'(-q);
            end
        end else begin
            if (q > Q_W'(32767)) begin
                sat_sample = 16'h7FFF;
            end else begin
                sat_sample = q[SAMPLE_W-1:0];
            end
        end
    end

    // Output register
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= sat_sample;
            r_out_last   <= r_last;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_m_ready;
    assign o_m_valid      = r_out_vld;
    assign o_m_sample     = r_out_sample;
    assign o_m_last       = r_out_last;

endmodule
